/* rtl/ptpd_pkg.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser package
// Shared types, phase encoding, data type codes and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

  // Field widths of the two channels and of the parse state.
  localparam int DATA_W  = 8;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 64;
  localparam int SKIP_W  = 32;
  localparam int IDX_W   = 3;
  localparam int ESIZE_W = 4;

  // Byte counts of the little-endian fields.
  localparam logic [3:0] COUNT_BYTES     = 4'd8;
  localparam logic [3:0] ARRAY_CNT_BYTES = 4'd4;
  localparam logic [3:0] LIST_CNT_BYTES  = 4'd2;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX = 3'd5;

  // Data type codes.
  localparam logic [CODE_W-1:0] TYPE_SCALAR_LO = 16'h0001;
  localparam logic [CODE_W-1:0] TYPE_SCALAR_HI = 16'h0008;
  localparam logic [CODE_W-1:0] TYPE_STRING    = 16'hFFFF;
  localparam logic [CODE_W-1:0] TYPE_ARRAY_LO  = 16'h4001;
  localparam logic [CODE_W-1:0] TYPE_ARRAY_HI  = 16'h4008;

  // Form flag codes.
  localparam logic [DATA_W-1:0] FORM_NONE  = 8'h00;
  localparam logic [DATA_W-1:0] FORM_RANGE = 8'h01;

  // Element size of a UTF-16 unit.
  localparam logic [ESIZE_W-1:0] ESIZE_STRING = 4'd2;

  // Parse phases. The numeric order matters: the span from PH_DEF to PH_L2S
  // is the set of phases where a truncated payload still reports a record.
  typedef enum logic [4:0] {
    PH_COUNT = 5'd0,
    PH_HDR   = 5'd1,
    PH_DEF   = 5'd2,
    PH_CUR   = 5'd3,
    PH_SDN   = 5'd4,
    PH_SDS   = 5'd5,
    PH_SCN   = 5'd6,
    PH_SCS   = 5'd7,
    PH_ADN   = 5'd8,
    PH_ADS   = 5'd9,
    PH_ACN   = 5'd10,
    PH_ACS   = 5'd11,
    PH_FLAG  = 5'd12,
    PH_FS    = 5'd13,
    PH_L2S   = 5'd14,
    PH_L1N   = 5'd15,
    PH_L1S   = 5'd16,
    PH_L2N   = 5'd17,
    PH_END   = 5'd18,
    PH_DONE  = 5'd19
  } phase_t;

  // One input word.
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } in_word_t;

  // Input holding register as seen by the parser.
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_hold_t;

  // One result word.
  typedef struct packed {
    logic [CODE_W-1:0]  property_code;
    logic [VALUE_W-1:0] current_value;
  } res_word_t;

  // Result of one parse step.
  typedef struct packed {
    logic      valid;
    res_word_t word;
  } res_t;

  // Byte count of a list: element count times a power-of-two element size,
  // modulo 2^32. A size of zero gives zero.
  function automatic logic [SKIP_W-1:0] scale_len(input logic [SKIP_W-1:0] cnt,
                                                   input logic [ESIZE_W-1:0] sz);
    logic [SKIP_W-1:0] len;
    case (sz)
      4'd1:    len = cnt;
      4'd2:    len = cnt << 1;
      4'd4:    len = cnt << 2;
      4'd8:    len = cnt << 3;
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic is_scalar(input logic [CODE_W-1:0] t);
    return (t >= TYPE_SCALAR_LO) && (t <= TYPE_SCALAR_HI);
  endfunction

endpackage

`default_nettype wire

/* rtl/ptpd_if.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser channels
// Valid/ready channel interfaces for payload bytes and parsed records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Payload byte channel.
interface ptpd_in_if import ptpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Parsed record channel.
interface ptpd_out_if import ptpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  property_code;
  logic [VALUE_W-1:0] current_value;

  modport source (output valid, output property_code, output current_value, input ready);
  modport sink   (input valid, input property_code, input current_value, output ready);
endinterface

`default_nettype wire

/* rtl/ptp_property_descriptor_parser_core.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser
// Parses a PTP device property list byte stream into (code, current value)
// records.
//
//   Channel  Dir  Payload                          Word
//   in_ch    in   data_byte[7:0], last_byte        one payload byte
//   out_ch   out  property_code[15:0],             one parsed record
//                 current_value[63:0]
//
// One byte is taken per cycle while out_ch is not stalled. The byte that
// closes a record passes the input register, and its record word then the
// result register. The whole per-byte transition is a single combinational
// step on the parse state, so the sustained rate is one byte per cycle.
// rst_n is synchronous; after reset the parser awaits the record count.
// A stalled out_ch holds its word; in_ch keeps flowing until the input
// register and the result register are both full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptp_property_descriptor_parser_core import ptpd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptpd_in_if.sink     in_ch,
  ptpd_out_if.source  out_ch
);

  in_hold_t hold;
  res_t     res;
  logic     out_free;
  logic     advance;

  // A held byte is parsed when the result register can take its outcome.
  assign advance = hold.valid && out_free;

  ptpd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .hold    (hold)
  );

  ptpd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .word    (hold.word),
    .res     (res)
  );

  ptpd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/ptpd_in_stage.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser input stage
// Holding register for one payload byte in front of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpd_in_stage import ptpd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptpd_in_if.sink     in_ch,
  input  wire logic   advance,
  output in_hold_t    hold
);

  logic     valid_r;
  in_word_t word_r;
  logic     take;

  // A new word enters when the register is empty or is drained this cycle.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (take) begin
      word_r.data_byte <= in_ch.data_byte;
      word_r.last_byte <= in_ch.last_byte;
    end
  end

  assign hold.valid = valid_r;
  assign hold.word  = word_r;

endmodule

`default_nettype wire

/* rtl/ptpd_parse.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser step logic
// Parse state and the per-byte transition, one byte per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpd_parse import ptpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step_en,
  input  in_word_t  word,
  output res_t      res
);

  // Parse state.
  phase_t              phase_r, phase_nxt;
  logic [VALUE_W-1:0]  records_r, records_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [VALUE_W-1:0]  asm_r, asm_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [CODE_W-1:0]   type_r, type_nxt;
  logic [ESIZE_W-1:0]  esize_r, esize_nxt;
  logic [VALUE_W-1:0]  cur_r, cur_nxt;
  logic                cur_ok_r, cur_ok_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;

  // Values after the type-specific step, before record close and last byte.
  phase_t              s_phase;
  logic [VALUE_W-1:0]  s_records;
  logic [IDX_W-1:0]    s_idx;
  logic [VALUE_W-1:0]  s_asm;
  logic [CODE_W-1:0]   s_code;
  logic [CODE_W-1:0]   s_type;
  logic [ESIZE_W-1:0]  s_esize;
  logic [VALUE_W-1:0]  s_cur;
  logic                s_cur_ok;
  logic [SKIP_W-1:0]   s_skip;

  logic [DATA_W-1:0]   b;
  logic [VALUE_W-1:0]  asm_take;
  logic [3:0]          idx_cnt;
  logic [ESIZE_W-1:0]  form_size;
  logic [1:0]          size_log;
  logic [SKIP_W-1:0]   len;
  logic [SKIP_W-1:0]   skip_dec;
  logic                skip_last;
  logic [VALUE_W-1:0]  records_dec;
  logic                emit_end;
  logic                emit_part;

  assign b           = word.data_byte;
  assign asm_take    = asm_r | (VALUE_W'(b) << {idx_r, 3'b000});
  assign idx_cnt     = {1'b0, idx_r} + 4'd1;
  assign form_size   = is_scalar(type_r) ? esize_r : '0;
  assign size_log    = 2'((type_r[3:0] - 4'd1) >> 1);
  assign skip_dec    = skip_r - SKIP_W'(1);
  assign skip_last   = (skip_r <= SKIP_W'(1));
  assign records_dec = records_r - VALUE_W'(1);

  // Per-phase transition of one byte.
  always_comb begin
    s_phase   = phase_r;
    s_records = records_r;
    s_idx     = idx_r;
    s_asm     = asm_r;
    s_code    = code_r;
    s_type    = type_r;
    s_esize   = esize_r;
    s_cur     = cur_r;
    s_cur_ok  = cur_ok_r;
    s_skip    = skip_r;
    len       = '0;
    case (phase_r)
      PH_COUNT: begin
        s_asm = asm_take;
        s_idx = idx_r + 3'd1;
        if (idx_cnt >= COUNT_BYTES) begin
          s_records = asm_take;
          s_phase   = (asm_take != '0) ? PH_HDR : PH_DONE;
          s_idx     = '0;
          s_asm     = '0;
        end
      end
      PH_HDR: begin
        case (idx_r)
          3'd0: begin
            s_code   = CODE_W'(b);
            s_cur    = '0;
            s_cur_ok = 1'b0;
          end
          3'd1:    s_code = {b, code_r[7:0]};
          3'd2:    s_type = CODE_W'(b);
          3'd3:    s_type = {b, type_r[7:0]};
          default: ;
        endcase
        s_idx = idx_r + 3'd1;
        if (idx_r >= HDR_LAST_IDX) begin
          // Decode the data type into a body layout.
          s_idx = '0;
          s_asm = '0;
          if (is_scalar(type_r)) begin
            s_esize = ESIZE_W'(1) << size_log;
            s_phase = PH_DEF;
          end else if (type_r == TYPE_STRING) begin
            s_esize = ESIZE_STRING;
            s_phase = PH_SDN;
          end else if (type_r >= TYPE_ARRAY_LO && type_r <= TYPE_ARRAY_HI) begin
            s_esize = ESIZE_W'(1) << size_log;
            s_phase = PH_ADN;
          end else begin
            s_phase = PH_DONE;
          end
        end
      end
      PH_DEF, PH_CUR: begin
        s_asm = asm_take;
        s_idx = idx_r + 3'd1;
        if (idx_cnt >= esize_r) begin
          if (phase_r == PH_CUR) begin
            s_cur    = asm_take;
            s_cur_ok = 1'b1;
            s_phase  = PH_FLAG;
          end else begin
            s_phase = PH_CUR;
          end
          s_idx = '0;
          s_asm = '0;
        end
      end
      PH_SDN, PH_SCN: begin
        len    = {SKIP_W'(b)} << 1;
        s_skip = len;
        s_idx  = '0;
        s_asm  = '0;
        if (phase_r == PH_SDN) begin
          s_phase = (len != '0) ? PH_SDS : PH_SCN;
        end else begin
          s_phase = (len != '0) ? PH_SCS : PH_FLAG;
        end
      end
      PH_ADN, PH_ACN, PH_L1N, PH_L2N: begin
        s_asm = asm_take;
        s_idx = idx_r + 3'd1;
        if ((phase_r == PH_ADN || phase_r == PH_ACN) && idx_cnt >= ARRAY_CNT_BYTES) begin
          len    = scale_len(asm_take[SKIP_W-1:0], esize_r);
          s_skip = len;
          s_idx  = '0;
          s_asm  = '0;
          if (phase_r == PH_ADN) begin
            s_phase = (len != '0) ? PH_ADS : PH_ACN;
          end else begin
            s_cur    = asm_take;
            s_cur_ok = 1'b1;
            s_phase  = (len != '0) ? PH_ACS : PH_FLAG;
          end
        end else if ((phase_r == PH_L1N || phase_r == PH_L2N) &&
                     idx_cnt >= LIST_CNT_BYTES) begin
          len    = scale_len(asm_take[SKIP_W-1:0], form_size);
          s_skip = len;
          s_idx  = '0;
          s_asm  = '0;
          if (phase_r == PH_L1N) begin
            s_phase = (len != '0) ? PH_L1S : PH_L2N;
          end else begin
            s_phase = (len != '0) ? PH_L2S : PH_END;
          end
        end
      end
      PH_SDS, PH_SCS, PH_ADS, PH_ACS, PH_FS, PH_L1S, PH_L2S: begin
        // Skip one byte; leave the phase on the last one.
        s_skip = skip_dec;
        if (skip_last) begin
          s_skip = '0;
          s_idx  = '0;
          s_asm  = '0;
          case (phase_r)
            PH_SDS:  s_phase = PH_SCN;
            PH_SCS:  s_phase = PH_FLAG;
            PH_ADS:  s_phase = PH_ACN;
            PH_ACS:  s_phase = PH_FLAG;
            PH_L1S:  s_phase = PH_L2N;
            default: s_phase = PH_END;
          endcase
        end
      end
      PH_FLAG: begin
        s_idx = '0;
        s_asm = '0;
        if (b == FORM_RANGE) begin
          len     = SKIP_W'(form_size) + (SKIP_W'(form_size) << 1);
          s_skip  = len;
          s_phase = (len != '0) ? PH_FS : PH_END;
        end else if (b == FORM_NONE) begin
          s_phase = PH_END;
        end else begin
          s_phase = PH_L1N;
        end
      end
      default: ;
    endcase
  end

  assign emit_end  = (s_phase == PH_END);
  assign emit_part = word.last_byte && (s_phase >= PH_DEF) && (s_phase <= PH_L2S);

  // Next state: close a finished record, then restart after the last byte.
  always_comb begin
    phase_nxt   = s_phase;
    records_nxt = s_records;
    idx_nxt     = s_idx;
    asm_nxt     = s_asm;
    code_nxt    = s_code;
    type_nxt    = s_type;
    esize_nxt   = s_esize;
    cur_nxt     = s_cur;
    cur_ok_nxt  = s_cur_ok;
    skip_nxt    = s_skip;
    if (emit_end) begin
      records_nxt = records_dec;
      phase_nxt   = (records_dec != '0) ? PH_HDR : PH_DONE;
      idx_nxt     = '0;
      asm_nxt     = '0;
    end
    if (word.last_byte) begin
      phase_nxt   = PH_COUNT;
      records_nxt = '0;
      idx_nxt     = '0;
      asm_nxt     = '0;
      code_nxt    = '0;
      type_nxt    = '0;
      esize_nxt   = '0;
      cur_nxt     = '0;
      cur_ok_nxt  = 1'b0;
      skip_nxt    = '0;
    end
  end

  // Outputs: one record word for a closed or truncated record.
  always_comb begin
    res.valid              = emit_end || emit_part;
    res.word.property_code = s_code;
    res.word.current_value = s_cur_ok ? s_cur : '0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COUNT;
      records_r <= '0;
      idx_r     <= '0;
      asm_r     <= '0;
      code_r    <= '0;
      type_r    <= '0;
      esize_r   <= '0;
      cur_r     <= '0;
      cur_ok_r  <= 1'b0;
      skip_r    <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      records_r <= records_nxt;
      idx_r     <= idx_nxt;
      asm_r     <= asm_nxt;
      code_r    <= code_nxt;
      type_r    <= type_nxt;
      esize_r   <= esize_nxt;
      cur_r     <= cur_nxt;
      cur_ok_r  <= cur_ok_nxt;
      skip_r    <= skip_nxt;
    end
  end

  // The record close phase is transient and is never held.
  a_no_end_held: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_END)
    else $error("record close phase held in state");

  // A skip phase always has bytes left to skip, and no other phase has any.
  a_skip_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) == (phase_r == PH_SDS || phase_r == PH_SCS || phase_r == PH_ADS ||
                       phase_r == PH_ACS || phase_r == PH_FS || phase_r == PH_L1S ||
                       phase_r == PH_L2S))
    else $error("skip count does not match phase");

  // The last byte returns the parser to the record count.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && word.last_byte |=> phase_r == PH_COUNT && records_r == '0 && !cur_ok_r)
    else $error("parser not restarted after last byte");

  // A closed record uses up exactly one record of the count.
  a_record_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && emit_end && !word.last_byte |=> records_r == $past(records_r) - VALUE_W'(1))
    else $error("record count not decremented on record close");

endmodule

`default_nettype wire

/* rtl/ptpd_out_stage.sv */
// ----------------------------------------------------------------------------
// PTP property descriptor parser output stage
// Result register that holds a record word until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpd_out_stage import ptpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic advance,
  input  res_t      res,
  output logic      out_free,
  ptpd_out_if.source out_ch
);

  logic      valid_r;
  res_word_t word_r;

  // The register can take a new result when empty or drained this cycle.
  assign out_free = !valid_r || out_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res.valid;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      word_r <= res.word;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.property_code = word_r.property_code;
  assign out_ch.current_value = word_r.current_value;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the PTP property descriptor parser
// Builds property list payloads (directed, then random), streams them into the
// parser one word per handshake, predicts the parsed records and checks each
// record word against the prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ptpd_pkg::*;

  localparam int TARGET_BYTES = 1500;
  localparam int QUIET_TAIL   = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 500000;

  // Scoreboard: tracks the parse state and holds the records still due.
  class record_scoreboard;
    phase_t      phase;
    logic [63:0] recs_left;
    logic [2:0]  fidx;
    logic [63:0] acc;
    logic [15:0] rec_code;
    logic [15:0] rec_type;
    logic [3:0]  esize;
    logic [63:0] cur_val;
    logic        cur_ok;
    logic [31:0] skip_left;
    res_word_t   due_q[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase     = PH_COUNT;
      recs_left = '0;
      fidx      = '0;
      acc       = '0;
      rec_code  = '0;
      rec_type  = '0;
      esize     = '0;
      cur_val   = '0;
      cur_ok    = 1'b0;
      skip_left = '0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void enter(phase_t p);
      phase = p;
      fidx  = '0;
      acc   = '0;
    endfunction

    function void enter_skip(logic [31:0] n, phase_t skip_ph, phase_t next_ph);
      skip_left = n;
      if (n != 0) enter(skip_ph);
      else enter(next_ph);
    endfunction

    function void skip_one(phase_t next_ph);
      if (skip_left <= 1) begin
        skip_left = '0;
        enter(next_ph);
      end else begin
        skip_left = skip_left - 1;
      end
    endfunction

    // Collects one little-endian byte; true once nbytes have arrived.
    function bit gather(logic [7:0] b, int unsigned nbytes);
      int unsigned idx;
      idx = fidx;
      acc = acc | (64'(b) << (8 * idx));
      if (idx + 1 >= nbytes) return 1'b1;
      fidx = 3'(idx + 1);
      return 1'b0;
    endfunction

    function bit scalar_type(logic [15:0] t);
      return (t >= TYPE_SCALAR_LO) && (t <= TYPE_SCALAR_HI);
    endfunction

    // Element size of the form lists: strings and arrays use zero.
    function logic [31:0] form_bytes();
      return scalar_type(rec_type) ? 32'(esize) : 32'd0;
    endfunction

    function void decode_header();
      if (scalar_type(rec_type)) begin
        esize = 4'(1 << ((rec_type - 16'd1) >> 1));
        enter(PH_DEF);
      end else if (rec_type == TYPE_STRING) begin
        esize = ESIZE_STRING;
        enter(PH_SDN);
      end else if (rec_type >= TYPE_ARRAY_LO && rec_type <= TYPE_ARRAY_HI) begin
        esize = 4'(1 << ((rec_type - TYPE_ARRAY_LO) >> 1));
        enter(PH_ADN);
      end else begin
        enter(PH_DONE);
      end
    endfunction

    function void push_record();
      res_word_t r;
      r.property_code = rec_code;
      r.current_value = cur_ok ? cur_val : 64'd0;
      due_q.push_back(r);
    endfunction

    // Advances the parse state by one accepted payload word.
    function void note_byte(logic [7:0] b, logic last);
      bit          emitted;
      logic [31:0] len;
      emitted = 1'b0;
      case (phase)
        PH_COUNT: begin
          if (gather(b, COUNT_BYTES)) begin
            recs_left = acc;
            if (acc != 0) enter(PH_HDR);
            else enter(PH_DONE);
          end
        end
        PH_HDR: begin
          case (fidx)
            3'd0: begin
              rec_code = {8'h00, b};
              cur_val  = '0;
              cur_ok   = 1'b0;
            end
            3'd1: rec_code[15:8] = b;
            3'd2: rec_type = {8'h00, b};
            3'd3: rec_type[15:8] = b;
            default: ;
          endcase
          if (fidx >= HDR_LAST_IDX) decode_header();
          else fidx = fidx + 3'd1;
        end
        PH_DEF: if (gather(b, esize)) enter(PH_CUR);
        PH_CUR: begin
          if (gather(b, esize)) begin
            cur_val = acc;
            cur_ok  = 1'b1;
            enter(PH_FLAG);
          end
        end
        PH_SDN: enter_skip({23'd0, b, 1'b0}, PH_SDS, PH_SCN);
        PH_SDS: skip_one(PH_SCN);
        PH_SCN: enter_skip({23'd0, b, 1'b0}, PH_SCS, PH_FLAG);
        PH_SCS: skip_one(PH_FLAG);
        PH_ADN: begin
          if (gather(b, ARRAY_CNT_BYTES)) begin
            len = acc[31:0] * 32'(esize);
            enter_skip(len, PH_ADS, PH_ACN);
          end
        end
        PH_ADS: skip_one(PH_ACN);
        PH_ACN: begin
          if (gather(b, ARRAY_CNT_BYTES)) begin
            cur_val = acc;
            cur_ok  = 1'b1;
            len = acc[31:0] * 32'(esize);
            enter_skip(len, PH_ACS, PH_FLAG);
          end
        end
        PH_ACS: skip_one(PH_FLAG);
        PH_FLAG: begin
          if (b == FORM_RANGE) enter_skip(form_bytes() * 3, PH_FS, PH_END);
          else if (b == FORM_NONE) enter(PH_END);
          else enter(PH_L1N);
        end
        PH_FS: skip_one(PH_END);
        PH_L1N: begin
          if (gather(b, LIST_CNT_BYTES)) begin
            len = acc[31:0] * form_bytes();
            enter_skip(len, PH_L1S, PH_L2N);
          end
        end
        PH_L1S: skip_one(PH_L2N);
        PH_L2N: begin
          if (gather(b, LIST_CNT_BYTES)) begin
            len = acc[31:0] * form_bytes();
            enter_skip(len, PH_L2S, PH_END);
          end
        end
        PH_L2S: skip_one(PH_END);
        default: ;
      endcase

      // A finished record is reported and the next one begins.
      if (phase == PH_END) begin
        push_record();
        emitted = 1'b1;
        recs_left = recs_left - 1;
        if (recs_left != 0) enter(PH_HDR);
        else enter(PH_DONE);
      end

      // The final word reports a record cut off inside its body.
      if (last) begin
        if (!emitted && phase >= PH_DEF && phase <= PH_L2S) push_record();
        clear();
      end
    endfunction

    function void check_record(logic [15:0] code, logic [63:0] value);
      res_word_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual code=%h value=%h",
                 $time, code, value);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (want.property_code !== code) begin
        $display("%0t: property_code mismatch, expected %h, actual %h",
                 $time, want.property_code, code);
        errors++;
      end
      if (want.current_value !== value) begin
        $display("%0t: current_value mismatch, expected %h, actual %h",
                 $time, want.current_value, value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptpd_in_if  in_ch ();
  ptpd_out_if out_ch ();

  ptp_property_descriptor_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  record_scoreboard sb = new();

  logic [7:0] pay_q[$];
  int         sent_bytes = 0;
  int         idle_odds = 0;
  bit         allow_idle = 1'b1;
  int         sink_odds = 0;
  int         stall_left = 0;
  int         cycle_cnt = 0;

  // Clock.
  always #10 clk = ~clk;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_record(out_ch.property_code, out_ch.current_value);
    end
  end

  // Run limit.
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stall bursts, with quiet stretches in between.
  initial begin
    int tick;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (tick % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: sink_odds = 0;
          1: sink_odds = 3;
          default: sink_odds = 8;
        endcase
      end
      tick++;
      if (!allow_idle) sink_odds = 0;
      if (stall_left != 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Appends a little-endian field to the payload under construction.
  function automatic void add_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) pay_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_fill(input int nbytes);
    for (int i = 0; i < nbytes; i++) pay_q.push_back(8'($urandom));
  endfunction

  // Small array count; sometimes with high bits that wrap away in the skip.
  function automatic logic [31:0] array_count(input int esz);
    logic [31:0] c;
    c = $urandom_range(0, 5);
    if (esz > 1 && $urandom_range(0, 5) == 0) begin
      case (esz)
        2: c = c | ($urandom << 31);
        4: c = c | ($urandom << 30);
        default: c = c | ($urandom << 29);
      endcase
    end
    return c;
  endfunction

  // One record; an unknown type gets its header only.
  function automatic void add_record(input logic [15:0] code, input logic [15:0] dtype,
                                     input logic [7:0] flag);
    int          esz;
    int          fs;
    logic [31:0] cnt;
    logic [31:0] len;
    logic [15:0] n;
    fs = 0;
    add_le(code, 2);
    add_le(dtype, 2);
    add_le($urandom, 2);
    if (dtype >= TYPE_SCALAR_LO && dtype <= TYPE_SCALAR_HI) begin
      esz = 1 << ((dtype - 1) >> 1);
      add_fill(2 * esz);
      fs = esz;
    end else if (dtype == TYPE_STRING) begin
      repeat (2) begin
        cnt = $urandom_range(0, 6);
        add_le(cnt, 1);
        add_fill(2 * cnt);
      end
    end else if (dtype >= TYPE_ARRAY_LO && dtype <= TYPE_ARRAY_HI) begin
      esz = 1 << ((dtype - TYPE_ARRAY_LO) >> 1);
      repeat (2) begin
        cnt = array_count(esz);
        add_le(cnt, 4);
        len = cnt * esz;
        add_fill(int'(len));
      end
    end else begin
      return;
    end
    add_le(flag, 1);
    if (flag == FORM_RANGE) begin
      add_fill(3 * fs);
    end else if (flag != FORM_NONE) begin
      repeat (2) begin
        n = (fs == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        add_le(n, 2);
        add_fill(n * fs);
      end
    end
  endfunction

  function automatic logic [15:0] pick_known_type();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(1, 8));
      1: return TYPE_STRING;
      default: return TYPE_ARRAY_LO + 16'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [15:0] pick_unknown_type();
    logic [15:0] t;
    case ($urandom_range(0, 5))
      0: t = 16'h0000;
      1: t = TYPE_SCALAR_HI + 16'd1;
      2: t = TYPE_ARRAY_LO - 16'd1;
      3: t = TYPE_ARRAY_HI + 16'd1;
      4: t = TYPE_STRING - 16'd1;
      default: begin
        t = 16'($urandom);
        if ((t >= TYPE_SCALAR_LO && t <= TYPE_SCALAR_HI) || t == TYPE_STRING ||
            (t >= TYPE_ARRAY_LO && t <= TYPE_ARRAY_HI)) t = 16'h8000;
      end
    endcase
    return t;
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(0, 5))
      0, 1: return FORM_NONE;
      2, 3: return FORM_RANGE;
      4: return 8'($urandom_range(2, 255));
      default: return 8'hFF;
    endcase
  endfunction

  // Sends one word; called and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends the built payload, marking its final word.
  task automatic send_payload(input int ignored_tail);
    for (int i = 0; i < pay_q.size(); i++) send_byte(pay_q[i], i == pay_q.size() - 1);
    sent_bytes += pay_q.size() - ignored_tail;
    pay_q.delete();
  endtask

  // Holds the sender until every due record has come out.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random payload: mostly well formed, some truncated, broken or noise.
  task automatic random_payload();
    int          nrec;
    int          mode;
    int          bad_at;
    int          cut;
    int          tail;
    logic [63:0] cnt;
    pay_q.delete();
    tail = 0;
    nrec = $urandom_range(1, 4);
    mode = $urandom_range(0, 19);
    if (!allow_idle) idle_odds = 0;
    else begin
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 3;
        2: idle_odds = 6;
        default: idle_odds = 12;
      endcase
    end
    if (mode == 19) begin
      add_fill($urandom_range(1, 12));
    end else if (mode == 18) begin
      add_le(64'd0, 8);
      tail = $urandom_range(1, 4);
      add_fill(tail);
    end else begin
      cnt = 64'(nrec);
      if (mode >= 13 && mode <= 15) begin
        case ($urandom_range(0, 2))
          0: cnt = 64'(nrec);
          1: cnt = 64'(nrec + $urandom_range(1, 3));
          default: cnt = {$urandom, $urandom};
        endcase
      end
      add_le(cnt, 8);
      bad_at = (mode >= 16) ? $urandom_range(0, nrec - 1) : -1;
      for (int i = 0; i < nrec; i++) begin
        if (i == bad_at) begin
          add_record(16'($urandom), pick_unknown_type(), FORM_NONE);
          break;
        end
        add_record(16'($urandom), pick_known_type(), pick_flag());
      end
      if (mode >= 13 && mode <= 15) begin
        cut = $urandom_range(1, pay_q.size());
        while (pay_q.size() > cut) void'(pay_q.pop_back());
      end else if (mode >= 16 || $urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, 4);
        add_fill(tail);
      end
    end
    send_payload(tail);
  endtask

  // Main sequence.
  initial begin
    bit paused;
    paused = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_odds = 4;

    // Zero record count: the rest of the payload is ignored.
    add_le(64'd0, 8);
    add_le(16'hFF00, 2);
    send_payload(2);

    // Scalar extremes, a repeated code and every kind of form flag.
    add_le(64'd4, 8);
    add_le(16'h0000, 2);
    add_le(TYPE_SCALAR_LO, 2);
    add_le(16'h0000, 2);
    add_le(8'h00, 1);
    add_le(8'hFF, 1);
    add_le(FORM_NONE, 1);
    add_le(16'hFFFF, 2);
    add_le(TYPE_SCALAR_HI, 2);
    add_le(16'hFFFF, 2);
    add_le(64'd0, 8);
    add_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    add_le(FORM_RANGE, 1);
    add_fill(24);
    add_le(16'hFFFF, 2);
    add_le(TYPE_SCALAR_HI, 2);
    add_le(16'h0000, 2);
    add_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    add_le(64'd0, 8);
    add_le(8'hFF, 1);
    add_le(16'd1, 2);
    add_fill(8);
    add_le(16'd2, 2);
    add_fill(16);
    add_record(16'h5A5A, 16'h0004, 8'h02);
    send_payload(0);

    // Strings and arrays; one array skip wraps around to zero length.
    add_le(64'd4, 8);
    add_record(16'h1001, TYPE_STRING, FORM_RANGE);
    add_record(16'h1002, TYPE_STRING, 8'h80);
    add_record(16'h1003, TYPE_ARRAY_LO, FORM_NONE);
    add_le(16'hA5A5, 2);
    add_le(TYPE_ARRAY_HI, 2);
    add_le(16'h0000, 2);
    add_le(32'h2000_0000, 4);
    add_le(32'hE000_0002, 4);
    add_fill(16);
    add_le(FORM_RANGE, 1);
    send_payload(0);

    // Unknown data type: no record, the rest is ignored.
    add_le(64'd2, 8);
    add_record(16'h1111, TYPE_SCALAR_HI + 16'd1, FORM_NONE);
    add_record(16'h2222, TYPE_SCALAR_LO, FORM_NONE);
    send_payload(9);

    // Payload ends inside the record count.
    add_le(64'd1, 4);
    send_payload(0);

    // Final word completes the header of a known type.
    add_le(64'd1, 8);
    add_le(16'hBEEF, 2);
    add_le(16'h0006, 2);
    add_le(16'h0000, 2);
    send_payload(0);

    // Payload ends inside the first form list count.
    add_le(64'd1, 8);
    add_le(16'hC0DE, 2);
    add_le(16'h0002, 2);
    add_le(16'h0000, 2);
    add_le(16'h3412, 2);
    add_le(8'h07, 1);
    add_le(8'h01, 1);
    send_payload(0);

    // Payload ends in the form skip: the current value is still reported.
    add_le(64'd1, 8);
    add_le(16'hD00D, 2);
    add_le(16'h0003, 2);
    add_le(16'h0000, 2);
    add_le(16'h1111, 2);
    add_le(16'h2222, 2);
    add_le(FORM_RANGE, 1);
    add_fill(3);
    send_payload(0);

    drain_results();
    sent_bytes = 0;

    // Random payloads; the tail of the run has no idling.
    while (sent_bytes < TARGET_BYTES) begin
      if (sent_bytes > TARGET_BYTES - QUIET_TAIL) allow_idle = 1'b0;
      if (!paused && sent_bytes > TARGET_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
      random_payload();
    end

    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0t: %0d mismatches, %0d records still due", $time, sb.errors,
               sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ptpd_pkg.sv
rtl/ptpd_if.sv
rtl/ptpd_in_stage.sv
rtl/ptpd_parse.sv
rtl/ptpd_out_stage.sv
rtl/ptp_property_descriptor_parser_core.sv
verif/tb_top.sv
